// ===== rtl/subband_qmf_synthesis_filter_unit_macros.svh =====
// assertion macros for the qmf synthesis filter unit
// no dependencies; included by the top level
`ifndef SUBBAND_QMF_SYNTHESIS_FILTER_UNIT_MACROS_SVH
`define SUBBAND_QMF_SYNTHESIS_FILTER_UNIT_MACROS_SVH

// same-cycle implication
`define SQS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sqs assertion failed");

// next-cycle implication
`define SQS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sqs assertion failed");

`endif

// ===== rtl/sqs_pkg.sv =====
// shared types, tap coefficients and output rounding for the qmf synthesis filter
// no dependencies
package sqs_pkg;

    localparam int SQS_TAP_COUNT = 24;
    localparam int SQS_IDX_W     = 5;
    localparam int SQS_SMP_W     = 15;
    localparam int SQS_HIST_W    = 16;
    localparam int SQS_COEF_W    = 13;
    localparam int SQS_PROD_W    = SQS_HIST_W + SQS_COEF_W;
    localparam int SQS_ACC_W     = 32;

    localparam logic signed [SQS_COEF_W-1:0] C_TAP_COEF [0:SQS_TAP_COUNT-1] = '{
        13'sd3,    -13'sd11,  -13'sd11,  13'sd53,   13'sd12,   -13'sd156,
        13'sd32,   13'sd362,  -13'sd210, -13'sd805, 13'sd951,  13'sd3876,
        13'sd3876, 13'sd951,  -13'sd805, -13'sd210, 13'sd362,  13'sd32,
        -13'sd156, 13'sd12,   13'sd53,   -13'sd11,  -13'sd11,  13'sd3
    };

    typedef struct packed {
        logic                 vld;
        logic                 last;
        logic [SQS_IDX_W-1:0] idx;
    } t_tap_ctl;

    // divide by 4096 toward zero, then clamp to 15 bits
    function automatic logic signed [SQS_SMP_W-1:0] sqs_finish(
        input logic signed [SQS_ACC_W-1:0] acc
    );
        logic signed [SQS_ACC_W-1:0] biased;
        logic signed [19:0]          q;
        logic signed [SQS_SMP_W-1:0] res;
        biased = acc + (acc[SQS_ACC_W-1] ? 32'sd4095 : 32'sd0);
        q      = biased[SQS_ACC_W-1:12];
        if (q > 20'sd16383) begin
            res = 15'sd16383;
        end else if (q < -20'sd16384) begin
            res = -15'sd16384;
        end else begin
            res = q[SQS_SMP_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== rtl/sqs_chan_if.sv =====
// handshake channels for subband sample pairs in and output sample pairs out
// depends on sqs_pkg
interface sqs_in_if import sqs_pkg::*;;
    logic                        valid;
    logic                        ready;
    logic signed [SQS_SMP_W-1:0] low_band_sample;
    logic signed [SQS_SMP_W-1:0] high_band_sample;

    modport source (output valid, output low_band_sample, output high_band_sample,
                    input ready);
    modport sink   (input valid, input low_band_sample, input high_band_sample,
                    output ready);
endinterface

interface sqs_out_if import sqs_pkg::*;;
    logic                        valid;
    logic                        ready;
    logic signed [SQS_SMP_W-1:0] first_output_sample;
    logic signed [SQS_SMP_W-1:0] second_output_sample;

    modport source (output valid, output first_output_sample,
                    output second_output_sample, input ready);
    modport sink   (input valid, input first_output_sample,
                    input second_output_sample, output ready);
endinterface

// ===== rtl/subband_qmf_synthesis_filter_unit.sv =====
// qmf synthesis filter: one sample pair in, one output sample pair out
// a new input pair is taken only in idle, once the previous result has been loaded into the output register
// the time per pair is set by the two ring writes, 24 serial tap reads, the mac pipeline and the output load
// the output register frees the input side while a result waits
// reset: synchronous active low, ring entries read as zero until written
`include "subband_qmf_synthesis_filter_unit_macros.svh"
// depends on sqs_pkg, sqs_chan_if, sqs_ring, sqs_mac
module subband_qmf_synthesis_filter_unit
    import sqs_pkg::*;
#(
    parameter int TAP_COUNT = SQS_TAP_COUNT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sqs_in_if.sink      i_in,
    sqs_out_if.source   o_out
);

    localparam int AW = $clog2(TAP_COUNT);

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_WR_DIFF = 5'b00010,
        S_RUN     = 5'b00100,
        S_DRAIN   = 5'b01000,
        S_EMIT    = 5'b10000
    } t_state;

    t_state                       r_state, n_state;
    logic [AW-1:0]                r_wp, n_wp;
    logic [AW-1:0]                r_rd, n_rd;
    logic [SQS_IDX_W-1:0]         r_tap, n_tap;
    logic signed [SQS_HIST_W-1:0] r_diff;
    t_tap_ctl                     r_ctl1, n_ctl;
    logic                         r_out_v, n_out_v;
    logic signed [SQS_SMP_W-1:0]  r_first, r_second;

    logic                         accept;
    logic                         load_out;
    logic                         we;
    logic [AW-1:0]                waddr;
    logic signed [SQS_HIST_W-1:0] wdata;
    logic signed [SQS_HIST_W-1:0] sum_w;
    logic signed [SQS_HIST_W-1:0] diff_w;
    logic signed [SQS_HIST_W-1:0] hist;
    logic                         mac_done;
    logic signed [SQS_SMP_W-1:0]  mac_first, mac_second;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
        return (a == AW'(TAP_COUNT - 1)) ? '0 : a + 1'b1;
    endfunction

    assign i_in.ready = (r_state == S_IDLE);
    assign accept     = i_in.valid && i_in.ready;
    assign load_out   = (r_state == S_EMIT) && (!r_out_v || o_out.ready);

    assign sum_w  = SQS_HIST_W'(i_in.low_band_sample) + SQS_HIST_W'(i_in.high_band_sample);
    assign diff_w = SQS_HIST_W'(i_in.low_band_sample) - SQS_HIST_W'(i_in.high_band_sample);

    assign we    = accept || (r_state == S_WR_DIFF);
    assign waddr = r_wp;
    assign wdata = (r_state == S_WR_DIFF) ? r_diff : sum_w;

    always_comb begin
        n_state = r_state;
        n_wp    = r_wp;
        n_rd    = r_rd;
        n_tap   = r_tap;
        n_ctl   = '0;
        n_out_v = r_out_v;
        if (o_out.valid && o_out.ready) begin
            n_out_v = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_wp    = wrap_inc(r_wp);
                    n_state = S_WR_DIFF;
                end
            end
            S_WR_DIFF: begin
                n_wp    = wrap_inc(r_wp);
                n_rd    = wrap_inc(r_wp);
                n_tap   = '0;
                n_state = S_RUN;
            end
            S_RUN: begin
                n_ctl.vld  = 1'b1;
                n_ctl.idx  = r_tap;
                n_ctl.last = (r_tap == SQS_IDX_W'(TAP_COUNT - 1));
                n_rd       = wrap_inc(r_rd);
                if (n_ctl.last) begin
                    n_tap   = '0;
                    n_state = S_DRAIN;
                end else begin
                    n_tap = r_tap + 1'b1;
                end
            end
            S_DRAIN: begin
                if (mac_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (load_out) begin
                    n_out_v = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wp    <= '0;
            r_rd    <= '0;
            r_tap   <= '0;
            r_ctl1  <= '0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wp    <= n_wp;
            r_rd    <= n_rd;
            r_tap   <= n_tap;
            r_ctl1  <= n_ctl;
            r_out_v <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_diff <= diff_w;
        end
        if (load_out) begin
            r_first  <= mac_first;
            r_second <= mac_second;
        end
    end

    sqs_ring #(
        .TAP_COUNT (TAP_COUNT),
        .AW        (AW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (r_state == S_RUN),
        .i_raddr (r_rd),
        .o_rdata (hist)
    );

    sqs_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (accept),
        .i_ctl    (r_ctl1),
        .i_hist   (hist),
        .o_done   (mac_done),
        .o_first  (mac_first),
        .o_second (mac_second)
    );

    assign o_out.valid                = r_out_v;
    assign o_out.first_output_sample  = r_first;
    assign o_out.second_output_sample = r_second;

    `SQS_ASSERT_IMP(a_wp_in_range, i_clk, i_rst_n, 1'b1, r_wp < AW'(TAP_COUNT))
    `SQS_ASSERT_NXT(a_accept_to_diff, i_clk, i_rst_n, accept, r_state == S_WR_DIFF)
    `SQS_ASSERT_IMP(a_out_from_emit, i_clk, i_rst_n, $rose(r_out_v), $past(r_state) == S_EMIT)
    `SQS_ASSERT_IMP(a_tap_idle, i_clk, i_rst_n, r_state != S_RUN, r_tap == '0)

endmodule

// ===== rtl/sqs_ring.sv =====
// history ring: one-write one-read synchronous memory with per-entry valid bits
// depends on sqs_pkg; unwritten entries read as zero
module sqs_ring
    import sqs_pkg::*;
#(
    parameter int TAP_COUNT = SQS_TAP_COUNT,
    parameter int AW        = $clog2(TAP_COUNT)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_we,
    input  logic [AW-1:0]                i_waddr,
    input  logic signed [SQS_HIST_W-1:0] i_wdata,
    input  logic                         i_re,
    input  logic [AW-1:0]                i_raddr,
    output logic signed [SQS_HIST_W-1:0] o_rdata
);

    logic signed [SQS_HIST_W-1:0] mem [TAP_COUNT];
    logic [TAP_COUNT-1:0]         r_valid;
    logic signed [SQS_HIST_W-1:0] r_rdata;
    logic                         r_rzero;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rzero <= 1'b1;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_rzero <= !r_valid[i_raddr];
            end
        end
    end

    assign o_rdata = r_rzero ? '0 : r_rdata;

endmodule

// ===== rtl/sqs_mac.sv =====
// shared multiply-accumulate: product register, then odd and even accumulators
// depends on sqs_pkg; rounding and clamping via sqs_finish
module sqs_mac
    import sqs_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_clear,
    input  t_tap_ctl                     i_ctl,
    input  logic signed [SQS_HIST_W-1:0] i_hist,
    output logic                         o_done,
    output logic signed [SQS_SMP_W-1:0]  o_first,
    output logic signed [SQS_SMP_W-1:0]  o_second
);

    t_tap_ctl                     r_ctl;
    logic signed [SQS_PROD_W-1:0] r_prod;
    logic signed [SQS_ACC_W-1:0]  r_acc_odd;
    logic signed [SQS_ACC_W-1:0]  r_acc_even;
    logic                         r_done;
    logic signed [SQS_PROD_W-1:0] n_prod;

    assign n_prod = SQS_PROD_W'(i_hist) * SQS_PROD_W'(C_TAP_COEF[i_ctl.idx]);

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl      <= '0;
            r_done     <= 1'b0;
            r_acc_odd  <= '0;
            r_acc_even <= '0;
        end else begin
            r_ctl  <= i_ctl;
            r_done <= r_ctl.vld && r_ctl.last;
            if (i_clear) begin
                r_acc_odd  <= '0;
                r_acc_even <= '0;
            end else if (r_ctl.vld) begin
                if (r_ctl.idx[0]) begin
                    r_acc_odd <= r_acc_odd + SQS_ACC_W'(r_prod);
                end else begin
                    r_acc_even <= r_acc_even + SQS_ACC_W'(r_prod);
                end
            end
        end
    end

    assign o_done   = r_done;
    assign o_first  = sqs_finish(r_acc_odd);
    assign o_second = sqs_finish(r_acc_even);

endmodule
